// ===== design/ffmd_pkg.sv =====
// Force feedback motor drive: shared types, widths, register indexes and
// controller/datapath handshake structs.
// No dependencies.
package ffmd_pkg;

    // Field widths
    localparam int POS_BITS   = 24;
    localparam int FORCE_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int DUTY_W     = 8;
    localparam int SPAN_W     = 23;
    localparam int SFORCE_W   = 14;
    localparam int VEL_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // Defaults for the top-level parameters
    localparam int HOLD_FORCE_DEF = 1000;
    localparam int FULL_SCALE_DEF = 10000;

    // Fixed constants
    localparam int LIM_HYST  = 5;     // limiter release margin
    localparam int DEAD_BAND = 5;     // |force| at or below gives zero duty
    localparam int DUTY_MAX  = 255;

    // Arithmetic widths
    localparam int MUL_A_W   = POS_BITS + 2;
    localparam int MUL_B_W   = FORCE_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 23;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_RANGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_HYSTERESIS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_FORCE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_FLOOR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_LOCK_EN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT_EN  = 3'd7;

    typedef struct packed {
        logic signed [FORCE_W-1:0]  force_cmd;
        logic signed [POS_BITS-1:0] position;
        logic signed [SPEED_W-1:0]  speed;
        logic                       stop_low;
        logic                       stop_high;
    } ffmd_in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_forward;
        logic [DUTY_W-1:0] duty_backward;
        logic              limiter_on;
    } ffmd_out_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic map_mul;    // register ramp product and zone decisions
        logic div_start;  // launch divider
        logic div_duty;   // divider takes full-scale divisor
        logic force_upd;  // register final force and pending limiter flag
        logic duty_mul;   // register duty product
        logic out_load;   // load output beat, commit limiter flag
    } ffmd_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic div_busy;
    } ffmd_stat_t;

endpackage

// ===== design/ffmd_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on ffmd_pkg for default widths.
module ffmd_div
    import ffmd_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int BITS_PER_STEP = 2;
    localparam int STEPS = NUM_W / BITS_PER_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   r_sh;

    // two compare-subtract steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        r_sh     = '0;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            r_sh     = {rem_next, quo_next[NUM_W-1]};
            quo_next = {quo_next[NUM_W-2:0], 1'b0};
            if (r_sh >= {1'b0, den_reg})
            begin
                r_sh        = r_sh - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = r_sh[DEN_W-1:0];
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(STEPS);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    // operands and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

// ===== design/ffmd_dp.sv =====
// Datapath: config registers, soft lock zone math, shared multiplier,
// divider, end stops, speed limiter, duty mapping and output register.
// Depends on ffmd_pkg and ffmd_div.
module ffmd_dp
    import ffmd_pkg::*;
#(
    parameter int HOLD_FORCE = HOLD_FORCE_DEF,
    parameter int FULL_SCALE = FULL_SCALE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ffmd_in_t              in_data,
    input  ffmd_cmd_t             cmd,
    output ffmd_stat_t            stat,
    output ffmd_out_t             out_data
);

    localparam int ZW = POS_BITS + 1;          // zone math width
    localparam int QW = DIV_NUM_W + 2;         // signed quotient plus offset
    localparam int VW = SPEED_W + 1;           // speed compare width
    localparam logic signed [FORCE_W-1:0] F_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] F_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
    localparam logic signed [QW-1:0] SAT_HI = QW'(F_MAX);
    localparam logic signed [QW-1:0] SAT_LO = QW'(F_MIN);

    // saturate a wide signed value to the force range
    function automatic logic signed [FORCE_W-1:0] sat_force(input logic signed [QW-1:0] v);
        logic signed [FORCE_W-1:0] r;
        if (v > SAT_HI)
            r = F_MAX;
        else if (v < SAT_LO)
            r = F_MIN;
        else
            r = v[FORCE_W-1:0];
        return r;
    endfunction

    // saturating negation
    function automatic logic signed [FORCE_W-1:0] neg_force(input logic signed [FORCE_W-1:0] v);
        logic signed [FORCE_W-1:0] r;
        if (v == F_MIN)
            r = F_MAX;
        else
            r = -v;
        return r;
    endfunction

    // config registers
    logic [SPAN_W-1:0]   travel_limit_reg, soft_range_reg, soft_hysteresis_reg;
    logic [SFORCE_W-1:0] soft_force_reg;
    logic [VEL_W-1:0]    max_velocity_reg;
    logic [DUTY_W-1:0]   pwm_floor_reg;
    logic                soft_lock_en_reg, speed_limit_en_reg;

    // item state
    ffmd_in_t                   in_reg;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       active_reg, mirror_reg, pos_case_reg, in_ramp_reg;
    logic                       den_zero_reg, den_neg_reg;
    logic signed [FORCE_W-1:0]  f_reg;
    logic [DIV_DEN_W-1:0]       den_map_reg;
    logic signed [FORCE_W-1:0]  g_reg, g_next;
    logic                       flag_pend_reg, flag_pend_next;
    logic                       flag_reg;
    ffmd_out_t                  out_reg, out_next;

    // zone signals
    logic signed [ZW-1:0]       p_x, s_x, h_x, r_x, sh_x, d_x, rh_x, rh_abs;
    logic                       lo_zone, hi_zone, pos_case, in_ramp, den_neg;
    logic signed [FORCE_W-1:0]  f_x;
    logic signed [MUL_A_W-1:0]  map_a, mul_a;
    logic signed [MUL_B_W-1:0]  map_b, mul_b, sf_b;
    logic [DIV_DEN_W-1:0]       den_map;

    // force stage signals
    logic [DIV_NUM_W-1:0]       quo;
    logic signed [QW-1:0]       q_s, off_s;
    logic signed [FORCE_W-1:0]  map_val, shaped, sf16, hold, g1, g2;
    logic                       q_neg, g2_pos, g2_neg, flag_t;
    logic signed [VW-1:0]       v_x, v_abs, vmax, vrel;

    // duty signals
    logic [FORCE_W:0]           mag;
    logic signed [FORCE_W:0]    g_x;
    logic [DUTY_W:0]            duty_span, sum9;
    logic [DUTY_W-1:0]          duty;
    logic                       g_pos, over;

    logic [PROD_W-1:0]          prod_abs;
    logic [DIV_NUM_W-1:0]       div_num;
    logic [DIV_DEN_W-1:0]       div_den;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_limit_reg    <= '0;
            soft_range_reg      <= '0;
            soft_hysteresis_reg <= '0;
            soft_force_reg      <= '0;
            max_velocity_reg    <= '1;
            pwm_floor_reg       <= '0;
            soft_lock_en_reg    <= 1'b0;
            speed_limit_en_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRAVEL_LIMIT:    travel_limit_reg    <= cfg_data[SPAN_W-1:0];
                REG_SOFT_RANGE:      soft_range_reg      <= cfg_data[SPAN_W-1:0];
                REG_SOFT_HYSTERESIS: soft_hysteresis_reg <= cfg_data[SPAN_W-1:0];
                REG_SOFT_FORCE:      soft_force_reg      <= cfg_data[SFORCE_W-1:0];
                REG_MAX_VELOCITY:    max_velocity_reg    <= cfg_data[VEL_W-1:0];
                REG_PWM_FLOOR:       pwm_floor_reg       <= cfg_data[DUTY_W-1:0];
                REG_SOFT_LOCK_EN:    soft_lock_en_reg    <= cfg_data[0];
                REG_SPEED_LIMIT_EN:  speed_limit_en_reg  <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // soft lock zone decision and ramp operands
    always_comb
    begin
        p_x     = {in_reg.position[POS_BITS-1], in_reg.position};
        s_x     = $signed(ZW'(travel_limit_reg)) - $signed(ZW'(soft_range_reg));
        h_x     = $signed(ZW'(soft_hysteresis_reg));
        r_x     = $signed(ZW'(soft_range_reg));
        lo_zone = (p_x <= -s_x);
        hi_zone = !lo_zone && (p_x >= s_x);
        d_x     = lo_zone ? -p_x : p_x;
        sh_x    = s_x + h_x;
        f_x     = hi_zone ? neg_force(in_reg.force_cmd) : in_reg.force_cmd;
        pos_case = !f_x[FORCE_W-1] && (soft_force_reg != '0);
        in_ramp  = (d_x <= sh_x);
        sf_b     = $signed(MUL_B_W'(soft_force_reg));
        // pull-away ramp: (d - s) * (F - f) / H + f
        // push ramp:      (d - s - H) * F / (R - H)
        if (pos_case)
        begin
            map_a = MUL_A_W'(d_x) - MUL_A_W'(s_x);
            map_b = sf_b - MUL_B_W'(f_x);
        end
        else
        begin
            map_a = MUL_A_W'(d_x) - MUL_A_W'(sh_x);
            map_b = sf_b;
        end
        rh_x    = r_x - h_x;
        den_neg = rh_x[ZW-1];
        rh_abs  = den_neg ? -rh_x : rh_x;
        den_map = pos_case ? DIV_DEN_W'(soft_hysteresis_reg) : rh_abs[DIV_DEN_W-1:0];
    end

    // shared multiplier
    always_comb
    begin
        g_x       = {g_reg[FORCE_W-1], g_reg};
        mag       = g_reg[FORCE_W-1] ? $unsigned(-g_x) : $unsigned(g_x);
        duty_span = (DUTY_W+1)'(DUTY_MAX) - {1'b0, pwm_floor_reg};
        if (cmd.duty_mul)
        begin
            mul_a = $signed(MUL_A_W'(mag));
            mul_b = $signed(MUL_B_W'(duty_span));
        end
        else
        begin
            mul_a = map_a;
            mul_b = map_b;
        end
        prod_next = mul_a * mul_b;
    end

    // input capture, product, zone decisions, force update and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_data;
        if (cmd.map_mul || cmd.duty_mul)
            prod_reg <= prod_next;
        if (cmd.map_mul)
        begin
            active_reg   <= soft_lock_en_reg && (lo_zone || hi_zone);
            mirror_reg   <= hi_zone;
            pos_case_reg <= pos_case;
            in_ramp_reg  <= in_ramp;
            den_zero_reg <= (den_map == '0);
            den_neg_reg  <= den_neg && !pos_case;
            f_reg        <= f_x;
            den_map_reg  <= den_map;
        end
        if (cmd.force_upd)
        begin
            g_reg         <= g_next;
            flag_pend_reg <= flag_pend_next;
        end
        if (cmd.out_load)
            out_reg <= out_next;
    end

    // divider operands
    always_comb
    begin
        prod_abs = prod_reg[PROD_W-1] ? $unsigned(-prod_reg) : $unsigned(prod_reg);
        div_num  = prod_abs[DIV_NUM_W-1:0];
        div_den  = cmd.div_duty ? DIV_DEN_W'(FULL_SCALE) : den_map_reg;
    end

    ffmd_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (stat.div_busy),
        .quo   (quo)
    );

    // shaped force, end stops, speed limiter
    always_comb
    begin
        q_neg   = prod_reg[PROD_W-1] ^ den_neg_reg;
        q_s     = $signed(QW'(quo));
        if (q_neg)
            q_s = -q_s;
        off_s   = pos_case_reg ? QW'(f_reg) : '0;
        map_val = sat_force(q_s + off_s);
        sf16    = $signed(FORCE_W'(soft_force_reg));
        case ({pos_case_reg, in_ramp_reg})
            2'b11:   shaped = den_zero_reg ? sf16 : map_val;
            2'b10:   shaped = sf16;
            2'b01:   shaped = '0;
            default: shaped = den_zero_reg ? sf16 : map_val;
        endcase
        if (!active_reg)
            g1 = in_reg.force_cmd;
        else if (mirror_reg)
            g1 = neg_force(shaped);
        else
            g1 = shaped;

        // end stops
        hold = $signed(FORCE_W'(HOLD_FORCE));
        if (g1[FORCE_W-1] && in_reg.stop_low)
            g2 = -hold;
        else if (!g1[FORCE_W-1] && (g1 != '0) && in_reg.stop_high)
            g2 = hold;
        else
            g2 = g1;

        // speed limiter
        g2_pos = !g2[FORCE_W-1] && (g2 != '0);
        g2_neg = g2[FORCE_W-1];
        v_x    = {in_reg.speed[SPEED_W-1], in_reg.speed};
        vmax   = $signed(VW'(max_velocity_reg));
        vrel   = vmax - $signed(VW'(LIM_HYST));
        v_abs  = v_x[VW-1] ? -v_x : v_x;
        flag_t = flag_reg || (v_x > vmax && g2_pos) || (v_x < -vmax && g2_neg);
        g_next = g2;
        flag_pend_next = flag_reg;
        if (speed_limit_en_reg)
        begin
            flag_pend_next = flag_t;
            if (flag_t)
            begin
                if (v_abs <= vrel)
                    flag_pend_next = 1'b0;
                else
                    g_next = '0;
            end
        end
    end

    // duty from quotient
    always_comb
    begin
        g_pos = !g_reg[FORCE_W-1] && (g_reg != '0);
        sum9  = {1'b0, quo[DUTY_W-1:0]} + {1'b0, pwm_floor_reg};
        over  = (quo[DIV_NUM_W-1:DUTY_W] != '0) || sum9[DUTY_W];
        duty  = over ? DUTY_W'(DUTY_MAX) : sum9[DUTY_W-1:0];
        if (mag <= (FORCE_W+1)'(DEAD_BAND))
            duty = '0;
        out_next.duty_forward  = g_pos ? duty : '0;
        out_next.duty_backward = g_pos ? '0 : duty;
        out_next.limiter_on    = flag_pend_reg;
    end

    // limiter flag commits with the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg <= 1'b0;
        else if (cmd.out_load)
            flag_reg <= flag_pend_reg;
    end

    assign out_data = out_reg;

endmodule

// ===== design/ffmd_ctrl.sv =====
// Controller: sequences one item through ramp multiply/divide, force update,
// duty multiply/divide and output load; owns both handshakes' flow control.
// Depends on ffmd_pkg.
module ffmd_ctrl
    import ffmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ffmd_stat_t stat,
    output ffmd_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MAP_MUL   = 4'd1;
    localparam logic [3:0] S_MAP_DIV   = 4'd2;
    localparam logic [3:0] S_MAP_WAIT  = 4'd3;
    localparam logic [3:0] S_FORCE     = 4'd4;
    localparam logic [3:0] S_DUTY_MUL  = 4'd5;
    localparam logic [3:0] S_DUTY_DIV  = 4'd6;
    localparam logic [3:0] S_DUTY_WAIT = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = (state_reg == S_IDLE);
        cmd.load      = in_valid && in_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_MAP_MUL;
            end
            S_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = S_MAP_DIV;
            end
            S_MAP_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_MAP_WAIT;
            end
            S_MAP_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_FORCE;
            end
            S_FORCE:
            begin
                cmd.force_upd = 1'b1;
                state_next    = S_DUTY_MUL;
            end
            S_DUTY_MUL:
            begin
                cmd.duty_mul = 1'b1;
                state_next   = S_DUTY_DIV;
            end
            S_DUTY_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_duty  = 1'b1;
                state_next    = S_DUTY_WAIT;
            end
            S_DUTY_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // divider is never relaunched mid-run
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    // a launch always shows up as busy
    a_div_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> stat.div_busy)
        else $error("divider did not go busy after start");

    // output register is never overwritten while holding an untaken beat
    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten");

    // no new input while a division is in flight
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.div_busy)
        else $error("input ready during division");

endmodule

// ===== design/force_feedback_motor_drive_core.sv =====
// One item at a time: a new input beat is taken only after the previous item
// has been loaded into the output register. Two 19-step, 2-bit-per-cycle
// divisions in the shared divider (soft lock ramp, then duty scaling) serve each item.
// Output register lets the core finish the next item while a beat waits.
// Reset (rst_n, async low): idle, no output beat, limiter flag clear,
// config registers cleared except max_velocity at 32767.
// Depends on ffmd_pkg, ffmd_ctrl, ffmd_dp (which holds ffmd_div).
module force_feedback_motor_drive_core
    import ffmd_pkg::*;
#(
    parameter int HOLD_FORCE = HOLD_FORCE_DEF,
    parameter int FULL_SCALE = FULL_SCALE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ffmd_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ffmd_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ffmd_cmd_t  cmd;
    ffmd_stat_t stat;

    // config writes are always accepted and land in the next cycle
    assign cfg_ready = 1'b1;

    ffmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffmd_dp #(
        .HOLD_FORCE (HOLD_FORCE),
        .FULL_SCALE (FULL_SCALE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

// ===== test/force_feedback_motor_drive_core_test.sv =====
// Self-checking testbench for force_feedback_motor_drive_core: random and directed
// servo ticks across several register settings, checked against an in-bench predictor.
// Depends on ffmd_pkg and the core RTL.
module force_feedback_motor_drive_core_test;
    import ffmd_pkg::*;

    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 3000;
    localparam int RANDOM_SETS  = 8;
    localparam int TICKS_PER_SET = 50;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    ffmd_in_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    ffmd_out_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Ticks waiting to be sent and duties waiting to be seen
    ffmd_in_t  ticks_pending[$];
    ffmd_out_t duty_expected[$];

    // Register shadow and limiter flag of the predictor
    logic [CFG_DATA_W-1:0] regs_now [8];
    logic                  speed_cut = 1'b0;

    int  beats_queued = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  calm         = 1'b0;

    force_feedback_motor_drive_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    function automatic longint clip16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Truncating linear ramp; a zero-length span yields the end value
    function automatic longint ramp_between(input longint x, input longint a, input longint b,
                                            input longint u, input longint v);
        if (b == a)
            return clip16(v);
        return clip16((x - a) * (v - u) / (b - a) + u);
    endfunction

    // Soft lock shaping at the low end; the high end reuses it mirrored
    function automatic longint lock_shape(input longint f, input longint d, input longint s,
                                          input longint h, input longint e,
                                          input longint fmax);
        if (f >= 0 && fmax > 0)
        begin
            if (d <= s + h)
                return ramp_between(d, s, s + h, f, fmax);
            return fmax;
        end
        if (d <= s + h)
            return 0;
        return ramp_between(d, s + h, e, 0, fmax);
    endfunction

    // Expected duties for one tick; updates the limiter flag
    function automatic ffmd_out_t predict_duty(input ffmd_in_t beat);
        longint    g, p, spd, t, r, h, f, vm, fl, mag, duty;
        ffmd_out_t res;
        g   = longint'($signed(beat.force_cmd));
        p   = longint'($signed(beat.position));
        spd = longint'($signed(beat.speed));
        t   = longint'(regs_now[REG_TRAVEL_LIMIT]);
        r   = longint'(regs_now[REG_SOFT_RANGE]);
        h   = longint'(regs_now[REG_SOFT_HYSTERESIS]);
        f   = longint'(regs_now[REG_SOFT_FORCE]);
        vm  = longint'(regs_now[REG_MAX_VELOCITY]);
        fl  = longint'(regs_now[REG_PWM_FLOOR]);

        if (regs_now[REG_SOFT_LOCK_EN][0])
        begin
            if (p <= r - t)
                g = lock_shape(g, -p, t - r, h, t, f);
            else if (p >= t - r)
                g = clip16(-lock_shape(clip16(-g), p, t - r, h, t, f));
        end

        // pushing into an active end stop
        if (g < 0 && beat.stop_low)
            g = -longint'(HOLD_FORCE_DEF);
        else if (g > 0 && beat.stop_high)
            g = HOLD_FORCE_DEF;

        if (regs_now[REG_SPEED_LIMIT_EN][0])
        begin
            if ((spd > vm && g > 0) || (spd < -vm && g < 0))
                speed_cut = 1'b1;
            if (speed_cut)
            begin
                if (((spd < 0) ? -spd : spd) <= vm - LIM_HYST)
                    speed_cut = 1'b0;
                else
                    g = 0;
            end
        end

        mag = (g < 0) ? -g : g;
        if (mag > DEAD_BAND)
        begin
            duty = mag * (DUTY_MAX - fl) / FULL_SCALE_DEF + fl;
            if (duty > DUTY_MAX)
                duty = DUTY_MAX;
        end
        else
            duty = 0;

        res.duty_forward  = (g > 0) ? DUTY_W'(duty) : '0;
        res.duty_backward = (g > 0) ? '0 : DUTY_W'(duty);
        res.limiter_on    = speed_cut;
        return res;
    endfunction

    function automatic longint jitter(input longint anchor, input int unsigned spread);
        return anchor + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    endfunction

    // Random tick, biased toward zone edges and the speed limit
    function automatic ffmd_in_t pick_beat();
        longint   t, r, h, vm, p, g, spd;
        ffmd_in_t beat;
        t  = longint'(regs_now[REG_TRAVEL_LIMIT]);
        r  = longint'(regs_now[REG_SOFT_RANGE]);
        h  = longint'(regs_now[REG_SOFT_HYSTERESIS]);
        vm = longint'(regs_now[REG_MAX_VELOCITY]);

        case ($urandom_range(0, 6))
            0: p = jitter(t, 12);
            1: p = jitter(t - r, 12);
            2: p = jitter(t - r + h, 12);
            3: p = jitter(t - r + h / 2, 12);
            4: p = jitter(0, 12);
            5: p = jitter(t + h, 12);
            default: p = longint'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        endcase
        if ($urandom_range(0, 1))
            p = -p;
        p = clamp(p, -8388608, 8388607);

        case ($urandom_range(0, 3))
            0: g = longint'($urandom_range(0, 65535)) - 32768;
            1: g = jitter(0, 8);
            default: g = longint'($urandom_range(0, 20000)) - 10000;
        endcase

        case ($urandom_range(0, 4))
            0: spd = longint'($urandom_range(0, 65535)) - 32768;
            1: spd = jitter(vm, 6);
            2: spd = jitter(vm - LIM_HYST, 3);
            default: spd = longint'($urandom_range(0, 2 * vm)) - vm;
        endcase
        if ($urandom_range(0, 1))
            spd = -spd;
        spd = clamp(spd, -32768, 32767);

        beat.force_cmd = FORCE_W'(g);
        beat.position  = POS_BITS'(p);
        beat.speed     = SPEED_W'(spd);
        beat.stop_low  = ($urandom_range(0, 3) == 0);
        beat.stop_high = ($urandom_range(0, 3) == 0);
        return beat;
    endfunction

    task automatic offer(input ffmd_in_t beat);
        ticks_pending.push_back(beat);
        beats_queued++;
    endtask

    task automatic add_beat(input longint g, input longint p, input longint spd,
                            input bit lo, input bit hi);
        ffmd_in_t beat;
        beat.force_cmd = FORCE_W'(g);
        beat.position  = POS_BITS'(p);
        beat.speed     = SPEED_W'(spd);
        beat.stop_low  = lo;
        beat.stop_high = hi;
        offer(beat);
    endtask

    // Wait until every queued tick has produced its result, then let the core settle
    task automatic settle();
        while (results_seen < beats_queued)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Write all eight registers back to back; call right after a rising edge
    task automatic apply_settings(input longint t, input longint r, input longint h,
                                  input longint f, input longint v, input longint fl,
                                  input bit lock_en, input bit lim_en);
        logic [CFG_DATA_W-1:0] plan [8];
        plan[REG_TRAVEL_LIMIT]    = CFG_DATA_W'(t);
        plan[REG_SOFT_RANGE]      = CFG_DATA_W'(r);
        plan[REG_SOFT_HYSTERESIS] = CFG_DATA_W'(h);
        plan[REG_SOFT_FORCE]      = CFG_DATA_W'(f);
        plan[REG_MAX_VELOCITY]    = CFG_DATA_W'(v);
        plan[REG_PWM_FLOOR]       = CFG_DATA_W'(fl);
        plan[REG_SOFT_LOCK_EN]    = CFG_DATA_W'(lock_en);
        plan[REG_SPEED_LIMIT_EN]  = CFG_DATA_W'(lim_en);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= plan[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            regs_now[i] = plan[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Sender: one tick per beat, random gaps unless calm
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                duty_expected.push_back(predict_duty(in_data));
            if (!in_valid || in_ready)
            begin
                if (ticks_pending.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= ticks_pending.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off while ticks keep coming
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 160 && ticks_pending.size() > 8)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Result checker
    always @(posedge clk)
    begin : check_duty
        ffmd_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (duty_expected.size() == 0)
                report_mismatch("result beat with nothing expected", 1, 0);
            else
            begin
                want = duty_expected.pop_front();
                if (out_data.duty_forward !== want.duty_forward)
                    report_mismatch("duty_forward", out_data.duty_forward,
                                    want.duty_forward);
                if (out_data.duty_backward !== want.duty_backward)
                    report_mismatch("duty_backward", out_data.duty_backward,
                                    want.duty_backward);
                if (out_data.limiter_on !== want.limiter_on)
                    report_mismatch("limiter_on", out_data.limiter_on, want.limiter_on);
            end
        end
    end

    // Cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("force_feedback_motor_drive_core_test failed");
        $finish;
    end

    initial
    begin
        longint t, r, h, f, v;
        foreach (regs_now[i])
            regs_now[i] = '0;
        regs_now[REG_MAX_VELOCITY] = 32767;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, dead band, end-stop hold
        add_beat(-32768, -8388608, -32768, 1'b0, 1'b0);
        add_beat(32767, 8388607, 32767, 1'b0, 1'b0);
        add_beat(0, 0, 0, 1'b1, 1'b1);
        add_beat(5, 100, 10, 1'b0, 1'b0);
        add_beat(-5, -100, -10, 1'b0, 1'b0);
        add_beat(6, 0, 0, 1'b0, 1'b0);
        add_beat(-6, 0, 0, 1'b0, 1'b0);
        add_beat(10000, 0, 0, 1'b0, 1'b0);
        add_beat(-10000, 0, 0, 1'b0, 1'b0);
        add_beat(-3000, 0, 0, 1'b1, 1'b0);
        add_beat(3000, 0, 0, 1'b0, 1'b1);
        add_beat(-3000, 0, 0, 1'b0, 1'b1);
        settle();

        // Soft lock ramps at both ends, limiter set, held and released
        apply_settings(1000, 300, 100, 3000, 2000, 40, 1'b1, 1'b1);
        add_beat(2000, -750, 0, 1'b0, 1'b0);
        add_beat(2000, -900, 0, 1'b0, 1'b0);
        add_beat(-2000, -750, 0, 1'b0, 1'b0);
        add_beat(-2000, -900, 0, 1'b0, 1'b0);
        add_beat(2000, 750, 0, 1'b0, 1'b0);
        add_beat(-2000, 750, 0, 1'b0, 1'b0);
        add_beat(-2000, 900, 0, 1'b0, 1'b0);
        add_beat(2000, 0, 2500, 1'b0, 1'b0);
        add_beat(2000, 0, 1996, 1'b0, 1'b0);
        add_beat(2000, 0, 1995, 1'b0, 1'b0);
        add_beat(-100, 0, -2500, 1'b0, 1'b0);
        settle();

        // Empty ramp past the travel end
        apply_settings(1000, 200, 200, 500, 32767, 0, 1'b1, 1'b0);
        add_beat(-100, -1500, 0, 1'b0, 1'b0);
        add_beat(100, 1500, 0, 1'b0, 1'b0);
        settle();

        // Empty ramp at the zone start
        apply_settings(1000, 200, 0, 800, 32767, 0, 1'b1, 1'b0);
        add_beat(100, -800, 0, 1'b0, 1'b0);
        settle();

        // Random ticks under extreme and random settings
        for (int set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            if (set_no == 0)
                apply_settings(8388607, 8388607, 8388607, 10000, 32767, 255, 1'b1, 1'b1);
            else if (set_no == 1)
                apply_settings(0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
            else
            begin
                t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23'h7FFFFF)
                                                : $urandom_range(0, 4000);
                r = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 23'h7FFFFF)
                                                : $urandom_range(0, t);
                h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, t)
                                                : $urandom_range(0, r);
                f = $urandom_range(0, 10000);
                v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                : $urandom_range(0, 3000);
                apply_settings(t, r, h, f, v, $urandom_range(0, 255),
                               $urandom_range(0, 3) != 0, $urandom_range(0, 1));
            end
            calm <= (set_no == 3);
            repeat (TICKS_PER_SET)
                offer(pick_beat());
            settle();
        end

        if (duty_expected.size() != 0)
            report_mismatch("expected results never seen", 0, duty_expected.size());
        if (mismatches == 0)
            $display("force_feedback_motor_drive_core_test passed");
        else
            $display("force_feedback_motor_drive_core_test failed");
        $finish;
    end
endmodule
